[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock, off while reset is low
`define EPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define EPD_NEVER(lbl, cond, msg) \
  `EPD_ASSERT(lbl, !(cond), msg)

`endif

[rtl/core/epd_pkg.sv]
// constants, series divisors and stage latencies of the ellipsoid plane distance pipeline
package epd_pkg;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [31:0] CONV_Q32    = 32'd4024455254;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [22:0] E2_Q30      = 23'd7188036;
  localparam logic [63:0] A_SHIFTED    = 64'd1632803072 << 30;
  localparam logic [63:0] A1E2_SHIFTED = 64'd1621872468 << 30;
  localparam logic [35:0] OUT_MAX     = 36'hF_FFFF_FFFF;

  localparam int unsigned SIN_STEPS = 7;
  localparam int unsigned COS_STEPS = 8;
  localparam int unsigned SIN_DIVS [SIN_STEPS] = '{210, 156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIVS [COS_STEPS] = '{240, 182, 132, 90, 56, 30, 12, 2};

  localparam int unsigned HSTEP_LAT      = 3;
  localparam int unsigned ROOT_W_BITS    = 31;
  localparam int unsigned QUOT_BITS      = 32;
  localparam int unsigned DIST_ROOT_BITS = 38;

  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned TRIG_LAT  = HSTEP_LAT * COS_STEPS;
  localparam int unsigned RADII_LAT = 3 + ROOT_W_BITS + 2 + QUOT_BITS + 1;
  localparam int unsigned LEGS_LAT  = 4 + DIST_ROOT_BITS + 1;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + TRIG_LAT + RADII_LAT + LEGS_LAT;

endpackage

[rtl/core/epd_delay.sv]
// fixed-length register delay line
module epd_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign d_o = sr_q[N-1];

endmodule

[rtl/core/epd_sqrt.sv]
// pipelined floor square root, one root bit per stage
module epd_sqrt #(
  parameter int unsigned RW = 31
) (
  input  logic            clk_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rad_q  [RW-1];
  logic [RW:0]     rem_q  [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [2*RW-1:0] rad_in;
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+2:0]   rem_try;
    logic [RW+2:0]   trial;
    logic            fit;
    logic [RW-1:0]   root_d;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign rem_try = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign fit     = rem_try >= trial;
    assign root_d  = {root_in[RW-2:0], fit};

    always_ff @(posedge clk_i) begin
      root_q[j] <= root_d;
    end

    if (j < RW - 1) begin : g_carry
      logic [2*RW-1:0] rad_d;
      logic [RW:0]     rem_d;

      assign rad_d = {rad_in[2*RW-3:0], 2'b00};
      assign rem_d = fit ? (RW+1)'(rem_try - trial) : (RW+1)'(rem_try);

      always_ff @(posedge clk_i) begin
        rad_q[j] <= rad_d;
        rem_q[j] <= rem_d;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

[rtl/core/epd_div.sv]
// pipelined restoring divider of a fixed dividend, one quotient bit per stage
module epd_div #(
  parameter int unsigned QW       = 32,
  parameter int unsigned DW       = 31,
  parameter logic [63:0] DIVIDEND = '0
) (
  input  logic          clk_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  localparam logic [DW-1:0] Rem0 = DW'(DIVIDEND >> QW);

  logic [DW-1:0] d_q   [QW-1];
  logic [DW-1:0] rem_q [QW-1];
  logic [QW-1:0] q_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] d_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   rem_try;
    logic          fit;
    logic [QW-1:0] q_d;

    if (j == 0) begin : g_first
      assign d_in   = d_i;
      assign rem_in = Rem0;
      assign q_in   = '0;
    end else begin : g_next
      assign d_in   = d_q[j-1];
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
    end

    assign rem_try = {rem_in, DIVIDEND[QW-1-j]};
    assign fit     = rem_try >= {1'b0, d_in};
    assign q_d     = {q_in[QW-2:0], fit};

    always_ff @(posedge clk_i) begin
      q_q[j] <= q_d;
    end

    if (j < QW - 1) begin : g_carry
      logic [DW-1:0] rem_d;

      assign rem_d = fit ? DW'(rem_try - {1'b0, d_in}) : DW'(rem_try);

      always_ff @(posedge clk_i) begin
        d_q[j]   <= d_in;
        rem_q[j] <= rem_d;
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

[rtl/core/epd_hstep.sv]
// one horner step of the series: f' = 1 - min(1, x2*f / k), three stages
module epd_hstep #(
  parameter int unsigned K = 2
) (
  input  logic        clk_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] f_i,
  output logic [31:0] x2_o,
  output logic [30:0] f_o
);

  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(K));
  localparam logic [7:0]  Kc    = 8'(K);

  logic [62:0] prod;
  logic [31:0] v_d, v_q, v2_q;
  logic [63:0] rprod;
  logic [31:0] q0_d, q0_q;
  logic [39:0] qk;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] t;
  logic [30:0] f_d, f_q;
  logic [31:0] x2_s1_q, x2_s2_q, x2_s3_q;

  // stage 1: product with the running term
  assign prod = {31'd0, x2_i} * {32'd0, f_i};
  assign v_d  = prod[61:30];

  // stage 2: reciprocal estimate of v / k
  assign rprod = {32'd0, v_q} * {32'd0, Recip};
  assign q0_d  = rprod[63:32];

  // stage 3: one correction, clamp and complement
  always_comb begin
    qk  = {8'd0, q0_q} * {32'd0, Kc};
    rem = v2_q - qk[31:0];
    q   = q0_q + 32'(rem >= {24'd0, Kc});
    t   = (q > {1'b0, epd_pkg::ONE_Q30}) ? {1'b0, epd_pkg::ONE_Q30} : q;
    f_d = 31'({1'b0, epd_pkg::ONE_Q30} - t);
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    x2_s1_q <= x2_i;
    q0_q    <= q0_d;
    v2_q    <= v_q;
    x2_s2_q <= x2_s1_q;
    f_q     <= f_d;
    x2_s3_q <= x2_s2_q;
  end

  assign x2_o = x2_s3_q;
  assign f_o  = f_q;

endmodule

[rtl/core/epd_front.sv]
// input stages: differences, scaling to radians, latitude fold and square
module epd_front (
  input  logic               clk_i,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  output logic [30:0]        phi_o,
  output logic [31:0]        x2_o,
  output logic [31:0]        dlat_o,
  output logic [32:0]        dlon_o
);

  logic signed [31:0] lsum, ldif;
  logic signed [32:0] odif;
  logic [31:0] sum_d, sum_q, dla_d, dla_q, dlo_d, dlo_q;
  logic [63:0] psum, pla, plo;
  logic [30:0] phr_d, phr_q;
  logic [31:0] dlat_d, dlat_q, dlat3_q, dlat4_q;
  logic [32:0] dlon_d, dlon_q, dlon3_q, dlon4_q;
  logic [30:0] phi_d, phi_q, phi4_q;
  logic [61:0] pp;
  logic [31:0] x2_d, x2_q;

  // stage 1: magnitudes of sum and differences
  always_comb begin
    lsum  = 32'(lat_a_i) + 32'(lat_b_i);
    ldif  = 32'(lat_a_i) - 32'(lat_b_i);
    odif  = 33'(lon_a_i) - 33'(lon_b_i);
    sum_d = lsum[31] ? 32'(-lsum) : 32'(lsum);
    dla_d = ldif[31] ? 32'(-ldif) : 32'(ldif);
    dlo_d = odif[32] ? 32'(-odif) : 32'(odif);
  end

  // stage 2: to radians
  always_comb begin
    psum   = {32'd0, sum_q} * {32'd0, epd_pkg::CONV_Q32};
    pla    = {32'd0, dla_q} * {32'd0, epd_pkg::CONV_Q32};
    plo    = {32'd0, dlo_q} * {32'd0, epd_pkg::CONV_Q32};
    phr_d  = psum[62:32];
    dlat_d = pla[62:31];
    dlon_d = plo[63:31];
  end

  // stage 3: fold past a right angle
  assign phi_d = (phr_q > epd_pkg::HALF_PI_Q30) ?
                 31'(epd_pkg::PI_Q30 - {1'b0, phr_q}) : phr_q;

  // stage 4: square of the mean latitude
  assign pp   = {31'd0, phi_q} * {31'd0, phi_q};
  assign x2_d = pp[61:30];

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    dla_q   <= dla_d;
    dlo_q   <= dlo_d;
    phr_q   <= phr_d;
    dlat_q  <= dlat_d;
    dlon_q  <= dlon_d;
    phi_q   <= phi_d;
    dlat3_q <= dlat_q;
    dlon3_q <= dlon_q;
    x2_q    <= x2_d;
    phi4_q  <= phi_q;
    dlat4_q <= dlat3_q;
    dlon4_q <= dlon3_q;
  end

  assign phi_o  = phi4_q;
  assign x2_o   = x2_q;
  assign dlat_o = dlat4_q;
  assign dlon_o = dlon4_q;

endmodule

[rtl/core/epd_trig.sv]
// series sine and cosine of the mean latitude as chains of horner steps
module epd_trig (
  input  logic        clk_i,
  input  logic [30:0] phi_i,
  input  logic [31:0] x2_i,
  output logic [30:0] s_o,
  output logic [30:0] c_o
);

  localparam int unsigned SinLat = epd_pkg::HSTEP_LAT * epd_pkg::SIN_STEPS;
  localparam int unsigned AlignLat =
    epd_pkg::HSTEP_LAT * (epd_pkg::COS_STEPS - epd_pkg::SIN_STEPS) - 1;

  logic [31:0] x2c [epd_pkg::COS_STEPS];
  logic [30:0] fc  [epd_pkg::COS_STEPS+1];
  logic [30:0] fs  [epd_pkg::SIN_STEPS+1];
  logic [30:0] phi_dly;
  logic [61:0] sp;
  logic [30:0] s_d, s_q;

  assign x2c[0] = x2_i;
  assign fc[0]  = epd_pkg::ONE_Q30;
  assign fs[0]  = epd_pkg::ONE_Q30;

  for (genvar j = 0; j < epd_pkg::COS_STEPS; j++) begin : g_cos
    if (j < epd_pkg::COS_STEPS - 1) begin : g_mid
      epd_hstep #(.K(epd_pkg::COS_DIVS[j])) u_step (
        .clk_i (clk_i),
        .x2_i  (x2c[j]),
        .f_i   (fc[j]),
        .x2_o  (x2c[j+1]),
        .f_o   (fc[j+1])
      );
    end else begin : g_last
      epd_hstep #(.K(epd_pkg::COS_DIVS[j])) u_step (
        .clk_i (clk_i),
        .x2_i  (x2c[j]),
        .f_i   (fc[j]),
        .x2_o  (),
        .f_o   (fc[j+1])
      );
    end
  end

  for (genvar j = 0; j < epd_pkg::SIN_STEPS; j++) begin : g_sin
    epd_hstep #(.K(epd_pkg::SIN_DIVS[j])) u_step (
      .clk_i (clk_i),
      .x2_i  (x2c[j]),
      .f_i   (fs[j]),
      .x2_o  (),
      .f_o   (fs[j+1])
    );
  end

  epd_delay #(.W(31), .N(SinLat)) u_phi_dly (
    .clk_i (clk_i),
    .d_i   (phi_i),
    .d_o   (phi_dly)
  );

  assign sp  = {31'd0, phi_dly} * {31'd0, fs[epd_pkg::SIN_STEPS]};
  assign s_d = sp[60:30];

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  epd_delay #(.W(31), .N(AlignLat)) u_s_dly (
    .clk_i (clk_i),
    .d_i   (s_q),
    .d_o   (s_o)
  );

  assign c_o = fc[epd_pkg::COS_STEPS];

endmodule

[rtl/core/epd_radii.sv]
// curvature radii: w2, its root, w2^1.5 and the two radius divisions
module epd_radii (
  input  logic        clk_i,
  input  logic [30:0] s_i,
  input  logic [30:0] c_i,
  output logic [31:0] m_o,
  output logic [31:0] nc_o
);

  logic [61:0] ss;
  logic [31:0] s2_d, s2_q;
  logic [54:0] ep;
  logic [24:0] e_d, e_q;
  logic [30:0] w2_d, w2_q;
  logic [30:0] rw, rwc_d, rwc_q, rwd_q;
  logic [30:0] w2_dly;
  logic [61:0] wp;
  logic [30:0] w15_d, w15_q;
  logic [31:0] n_div, m_div, m_q;
  logic [30:0] c_dly;
  logic [62:0] np;
  logic [31:0] nc_d, nc_q;

  assign ss   = {31'd0, s_i} * {31'd0, s_i};
  assign s2_d = ss[61:30];
  assign ep   = {32'd0, epd_pkg::E2_Q30} * {23'd0, s2_q};
  assign e_d  = ep[54:30];
  assign w2_d = epd_pkg::ONE_Q30 - {6'd0, e_q};

  epd_sqrt #(.RW(epd_pkg::ROOT_W_BITS)) u_root (
    .clk_i  (clk_i),
    .rad_i  ({1'b0, w2_q, 30'd0}),
    .root_o (rw)
  );

  epd_delay #(.W(31), .N(epd_pkg::ROOT_W_BITS + 1)) u_w2_dly (
    .clk_i (clk_i),
    .d_i   (w2_q),
    .d_o   (w2_dly)
  );

  assign rwc_d = (rw == '0) ? 31'd1 : rw;
  assign wp    = {31'd0, w2_dly} * {31'd0, rwc_q};
  assign w15_d = (wp[60:30] == '0) ? 31'd1 : wp[60:30];

  always_ff @(posedge clk_i) begin
    s2_q  <= s2_d;
    e_q   <= e_d;
    w2_q  <= w2_d;
    rwc_q <= rwc_d;
    w15_q <= w15_d;
    rwd_q <= rwc_q;
  end

  epd_div #(
    .QW       (epd_pkg::QUOT_BITS),
    .DW       (31),
    .DIVIDEND (epd_pkg::A_SHIFTED)
  ) u_div_n (
    .clk_i (clk_i),
    .d_i   (rwd_q),
    .q_o   (n_div)
  );

  epd_div #(
    .QW       (epd_pkg::QUOT_BITS),
    .DW       (31),
    .DIVIDEND (epd_pkg::A1E2_SHIFTED)
  ) u_div_m (
    .clk_i (clk_i),
    .d_i   (w15_q),
    .q_o   (m_div)
  );

  epd_delay #(.W(31), .N(epd_pkg::RADII_LAT - 1)) u_c_dly (
    .clk_i (clk_i),
    .d_i   (c_i),
    .d_o   (c_dly)
  );

  assign np   = {31'd0, n_div} * {32'd0, c_dly};
  assign nc_d = np[61:30];

  always_ff @(posedge clk_i) begin
    nc_q <= nc_d;
    m_q  <= m_div;
  end

  assign m_o  = m_q;
  assign nc_o = nc_q;

endmodule

[rtl/core/epd_legs.sv]
// legs in millimetres, split squares, sum and final root with saturation
module epd_legs (
  input  logic        clk_i,
  input  logic [31:0] m_i,
  input  logic [31:0] nc_i,
  input  logic [31:0] dlat_i,
  input  logic [32:0] dlon_i,
  output logic [35:0] dist_o
);

  logic [63:0] pm;
  logic [64:0] pn;
  logic [33:0] pm_d, pm_q;
  logic [34:0] pn_d, pn_q;
  logic [43:0] sm;
  logic [44:0] sn;
  logic [35:0] t1_d, t1_q;
  logic [36:0] t2_d, t2_q;
  logic        sat_d, sat_q, sat_dly;
  logic [35:0] hh1_d, hl1_d, ll1_d, hh2_d, hl2_d, ll2_d;
  logic [35:0] hh1_q, hl1_q, ll1_q, hh2_q, hl2_q, ll2_q;
  logic [72:0] sum_d, sum_q;
  logic [37:0] root;
  logic [35:0] dist_d, dist_q;

  // stage 1: radius times angle
  always_comb begin
    pm   = {32'd0, m_i} * {32'd0, dlat_i};
    pn   = {33'd0, nc_i} * {32'd0, dlon_i};
    pm_d = pm[63:30];
    pn_d = pn[64:30];
  end

  // stage 2: metres in q8 to millimetres
  always_comb begin
    sm   = {10'd0, pm_q} * 44'd1000;
    sn   = {10'd0, pn_q} * 45'd1000;
    t1_d = sm[43:8];
    t2_d = sn[44:8];
  end

  // stage 3: partial products of the squares
  always_comb begin
    sat_d = t2_q[36];
    hh1_d = t1_q[35:18] * t1_q[35:18];
    hl1_d = t1_q[35:18] * t1_q[17:0];
    ll1_d = t1_q[17:0] * t1_q[17:0];
    hh2_d = t2_q[35:18] * t2_q[35:18];
    hl2_d = t2_q[35:18] * t2_q[17:0];
    ll2_d = t2_q[17:0] * t2_q[17:0];
  end

  // stage 4: exact sum of squares
  assign sum_d = ((73'(hh1_q) + 73'(hh2_q)) << 36)
               + ((73'(hl1_q) + 73'(hl2_q)) << 19)
               + (73'(ll1_q) + 73'(ll2_q));

  always_ff @(posedge clk_i) begin
    pm_q  <= pm_d;
    pn_q  <= pn_d;
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    sat_q <= sat_d;
    hh1_q <= hh1_d;
    hl1_q <= hl1_d;
    ll1_q <= ll1_d;
    hh2_q <= hh2_d;
    hl2_q <= hl2_d;
    ll2_q <= ll2_d;
    sum_q <= sum_d;
  end

  epd_sqrt #(.RW(epd_pkg::DIST_ROOT_BITS)) u_root (
    .clk_i  (clk_i),
    .rad_i  ({3'd0, sum_q}),
    .root_o (root)
  );

  epd_delay #(.W(1), .N(epd_pkg::DIST_ROOT_BITS + 1)) u_sat_dly (
    .clk_i (clk_i),
    .d_i   (sat_q),
    .d_o   (sat_dly)
  );

  assign dist_d = (sat_dly || (root[37:36] != 2'b00)) ? epd_pkg::OUT_MAX : root[35:0];

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

[rtl/core/ellipsoid_plane_distance.sv]
// top level of the ellipsoid plane distance pipeline
//
// Distance between two positions (latitude and longitude in 1e-7 degree)
// on the reference ellipsoid projected to a plane, in millimetres.
// A transfer in is taken at each rising edge with start high and busy low;
// busy stays low, so a new point pair can enter in every cycle.
// The result appears on distance_mm_o with done_o high for one cycle,
// in the same order as the transfers that caused it.
// Throughput is one pair per cycle; the latency is set by the chain of
// series steps and bit-per-stage units: a 31-stage root, two
// parallel 32-stage radius dividers and a 38-stage final root.
// Reset clears the valid chain only: no result is shown until a new
// transfer has gone all the way through. The receiver cannot stall, and
// nothing in the pipeline ever waits.
// Distances beyond the 36-bit range read as all ones.
`include "assert_macros.svh"

module ellipsoid_plane_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  output logic               done_o,
  output logic [35:0]        distance_mm_o
);

  localparam int unsigned DiffLat = epd_pkg::TRIG_LAT + epd_pkg::RADII_LAT;

  logic [epd_pkg::TOTAL_LAT-1:0] vld_d, vld_q;
  logic [30:0] phi;
  logic [31:0] x2;
  logic [31:0] dlat;
  logic [32:0] dlon;
  logic [30:0] s_val, c_val;
  logic [31:0] m_val, nc_val;
  logic [64:0] diff_dly;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[epd_pkg::TOTAL_LAT-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  epd_front u_front (
    .clk_i   (clk_i),
    .lat_a_i (lat_a_i),
    .lon_a_i (lon_a_i),
    .lat_b_i (lat_b_i),
    .lon_b_i (lon_b_i),
    .phi_o   (phi),
    .x2_o    (x2),
    .dlat_o  (dlat),
    .dlon_o  (dlon)
  );

  epd_trig u_trig (
    .clk_i (clk_i),
    .phi_i (phi),
    .x2_i  (x2),
    .s_o   (s_val),
    .c_o   (c_val)
  );

  epd_radii u_radii (
    .clk_i (clk_i),
    .s_i   (s_val),
    .c_i   (c_val),
    .m_o   (m_val),
    .nc_o  (nc_val)
  );

  epd_delay #(.W(65), .N(DiffLat)) u_diff_dly (
    .clk_i (clk_i),
    .d_i   ({dlon, dlat}),
    .d_o   (diff_dly)
  );

  epd_legs u_legs (
    .clk_i  (clk_i),
    .m_i    (m_val),
    .nc_i   (nc_val),
    .dlat_i (diff_dly[31:0]),
    .dlon_i (diff_dly[64:32]),
    .dist_o (distance_mm_o)
  );

  assign done_o = vld_q[epd_pkg::TOTAL_LAT-1];

  `EPD_ASSERT(a_done_follows, (start && !busy) |-> ##(epd_pkg::TOTAL_LAT) done_o, "result missing")
  `EPD_ASSERT(a_done_cause, done_o |-> $past(start && !busy, epd_pkg::TOTAL_LAT), "result without transfer")
  `EPD_ASSERT(a_no_extra, !(start && !busy) |-> ##(epd_pkg::TOTAL_LAT) !done_o, "extra result")

endmodule

[tb/sv/ellipsoid_plane_distance_tb.sv]
// self-checking testbench of the ellipsoid plane distance pipeline
`timescale 1ns / 1ps

module ellipsoid_plane_distance_tb;

  localparam int unsigned N_RANDOM = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_ROWS = 16;
  localparam int unsigned N_ITEMS = N_ROWS + N_RANDOM;

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    bit                 known;
    logic [35:0]        exp_mm;
  } pair_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] lat_a_i = '0;
  logic signed [31:0] lon_a_i = '0;
  logic signed [30:0] lat_b_i = '0;
  logic signed [31:0] lon_b_i = '0;
  logic               done_o;
  logic [35:0]        distance_mm_o;

  logic [35:0] expected_mm [N_ITEMS];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          idle_on = 1'b0;

  ellipsoid_plane_distance dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .lat_a_i,
    .lon_a_i,
    .lat_b_i,
    .lon_b_i,
    .done_o,
    .distance_mm_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v, int bits);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int i = bits - 1; i >= 0; i--) begin
      c  = r | (64'd1 << i);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] series(logic [63:0] x2, bit even);
    logic [63:0] f;
    logic [63:0] t;
    int unsigned n;
    int unsigned d;
    f = 64'(epd_pkg::ONE_Q30);
    n = even ? epd_pkg::COS_STEPS : epd_pkg::SIN_STEPS;
    for (int i = 0; i < n; i++) begin
      d = even ? epd_pkg::COS_DIVS[i] : epd_pkg::SIN_DIVS[i];
      t = ((x2 * f) >> 30) / d;
      f = 64'(epd_pkg::ONE_Q30) -
          (t > 64'(epd_pkg::ONE_Q30) ? 64'(epd_pkg::ONE_Q30) : t);
    end
    return f;
  endfunction

  function automatic logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [35:0] hubeny_mm(logic signed [30:0] la_f, logic signed [31:0] oa_f,
                                            logic signed [30:0] lb_f, logic signed [31:0] ob_f);
    longint       la, oa, lb, ob;
    logic [63:0]  phi, x2, s_q, c_q, s2, w2, rw, w15, n_q8, m_q8, nc;
    logic [63:0]  dlat, dlon, t1, t2, r;
    logic [127:0] sq;
    la = la_f; oa = oa_f; lb = lb_f; ob = ob_f;
    phi = mul_shr(magn(la + lb), 64'(epd_pkg::CONV_Q32), 32);
    if (phi > 64'(epd_pkg::HALF_PI_Q30)) phi = 64'(epd_pkg::PI_Q30) - phi;
    x2  = (phi * phi) >> 30;
    s_q = (phi * series(x2, 1'b0)) >> 30;
    c_q = series(x2, 1'b1);
    s2  = (s_q * s_q) >> 30;
    w2  = 64'(epd_pkg::ONE_Q30) - ((64'(epd_pkg::E2_Q30) * s2) >> 30);
    rw  = isqrt({64'd0, w2 << 30}, 31);
    if (rw == 0) rw = 1;
    w15 = (w2 * rw) >> 30;
    if (w15 == 0) w15 = 1;
    n_q8 = epd_pkg::A_SHIFTED / rw;
    m_q8 = epd_pkg::A1E2_SHIFTED / w15;
    nc   = (n_q8 * c_q) >> 30;
    dlat = mul_shr(magn(la - lb), 64'(epd_pkg::CONV_Q32), 31);
    dlon = mul_shr(magn(oa - ob), 64'(epd_pkg::CONV_Q32), 31);
    t1 = (mul_shr(m_q8, dlat, 30) * 64'd1000) >> 8;
    t2 = (mul_shr(nc, dlon, 30) * 64'd1000) >> 8;
    if (t1 > 64'(epd_pkg::OUT_MAX) || t2 > 64'(epd_pkg::OUT_MAX)) return epd_pkg::OUT_MAX;
    sq = {64'd0, t1} * {64'd0, t1} + {64'd0, t2} * {64'd0, t2};
    r  = isqrt(sq, 38);
    return r > 64'(epd_pkg::OUT_MAX) ? epd_pkg::OUT_MAX : r[35:0];
  endfunction

  // one transfer in, with a random idle gap drawn before it while idle_on is set
  task automatic send_pair(pair_row_t p);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    forever begin
      @(negedge clk_i);
      start   <= 1'b1;
      lat_a_i <= p.lat_a;
      lon_a_i <= p.lon_a;
      lat_b_i <= p.lat_b;
      lon_b_i <= p.lon_b;
      @(posedge clk_i);
      if (!busy) break;
    end
    expected_mm[sent] = p.known ? p.exp_mm : hubeny_mm(p.lat_a, p.lon_a, p.lat_b, p.lon_b);
    sent++;
  endtask

  function automatic logic signed [30:0] rand_lat(int unsigned kind);
    case (kind)
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'sd900000000 : -31'sd900000000;
      default: return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_lon(int unsigned kind);
    case (kind)
      0: return 32'($urandom);
      default: return 32'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ellipsoid_plane_distance_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (checked == sent) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", distance_mm_o);
      end else begin
        logic [35:0] want;
        want = expected_mm[checked];
        checked++;
        if (distance_mm_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, distance_mm_o);
        end
      end
    end
  end

  pair_row_t rows [N_ROWS] = '{
    '{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b1, 36'd0},
    '{31'sd356000000, 32'sd1397000000, 31'sd356000000, 32'sd1397000000, 1'b1, 36'd0},
    '{-31'sd900000000, -32'sd1800000000, -31'sd900000000, -32'sd1800000000, 1'b1, 36'd0},
    '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, 1'b0, 36'd0},
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1, 1'b0, 36'd0},
    '{31'sd0, 32'sd0, 31'sd1, 32'sd0, 1'b0, 36'd0},
    '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b0, 36'd0},
    '{31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000, 1'b0, 36'd0},
    '{31'sd899999999, 32'sd123, 31'sd900000000, -32'sd456, 1'b0, 36'd0},
    '{31'h3FFF_FFFF, 32'h7FFF_FFFF, -31'sh4000_0000, 32'sh8000_0000, 1'b0, 36'd0},
    '{31'h3FFF_FFFF, 32'sd0, 31'h3FFF_FFFF, 32'sd10, 1'b0, 36'd0},
    '{-31'sh4000_0000, 32'sh8000_0000, -31'sh4000_0000, 32'h7FFF_FFFF, 1'b0, 36'd0},
    '{31'sd1000000000, 32'sd0, 31'sd1000000000, 32'sd1000000, 1'b0, 36'd0},
    '{31'sd450000000, 32'sd0, 31'sd450000000, 32'sd900000000, 1'b0, 36'd0},
    '{-31'sd123456789, 32'sd987654321, 31'sd23456789, -32'sd87654321, 1'b0, 36'd0},
    '{31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000, 1'b0, 36'd0}
  };

  initial begin
    pair_row_t p;
    int unsigned kind;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_pair(rows[i]);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      p.known  = 1'b0;
      p.exp_mm = '0;
      p.lat_a  = rand_lat(kind < 2 ? 0 : (kind == 2 ? 1 : 2));
      p.lon_a  = rand_lon(kind < 2 ? 0 : 1);
      if (kind >= 5) begin
        // nearby point on a track
        p.lat_b = p.lat_a + 31'(int'($urandom_range(0, 200000)) - 100000);
        p.lon_b = p.lon_a + 32'(int'($urandom_range(0, 200000)) - 100000);
      end else begin
        p.lat_b = rand_lat(kind < 2 ? 0 : 2);
        p.lon_b = rand_lon(kind < 2 ? 0 : 1);
      end
      send_pair(p);
    end
    @(negedge clk_i);
    start <= 1'b0;

    wait (checked == sent);
    repeat (epd_pkg::TOTAL_LAT + 10) @(posedge clk_i);
    $display("%0d point pairs sent, %0d distances checked, %0d mismatches",
             sent, checked, mismatches);
    $display("directed extremes, out-of-range latitudes, nearby and far pairs, random gaps");
    if (mismatches == 0 && checked == sent) begin
      $display("ellipsoid_plane_distance_tb: PASS");
    end else begin
      $display("ellipsoid_plane_distance_tb: FAIL");
    end
    $finish;
  end

endmodule
